FILE: src/escape_time_fractal_pixel_core_macros.svh
// Assertion helpers shared by the fractal core modules.
// Each use expects clk_i and rst_ni in the enclosing module.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/etfp_pkg.sv
package etfp_pkg;

  // Fixed point format and escape radius
  localparam int unsigned FRAC_BITS = 28;
  localparam logic [63:0] ESCAPE_SQ = 64'h0400_0000_0000_0000; // 4.0 in Q8.56

  // Image and palette geometry
  localparam int unsigned IMAGE_SIDE  = 4096;
  localparam int unsigned COLOR_COUNT = 256;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTAL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM        = 3'd6;

  // Fractal selection
  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  typedef struct packed {
    logic               fractal_mode;
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        pixel_pitch;
    logic [15:0]        iteration_limit;
    logic signed [31:0] julia_re;
    logic signed [31:0] julia_im;
  } cfg_t;

  typedef struct packed {
    logic coord_mul;  // multiply pixel indexes by the pitch
    logic start;      // form the point, load z and c, clear count
    logic sq_mul;     // form the three products of z
    logic advance;    // z <= z*z + c, count up
    logic load_out;   // move count into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic stop;       // escaped or out of iterations
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FORM,
    ST_MUL,
    ST_CHECK,
    ST_DONE
  } state_e;

endpackage

FILE: src/etfp_ctrl.sv
`include "escape_time_fractal_pixel_core_macros.svh"

module etfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  etfp_pkg::dp_status_t status_i,
  output etfp_pkg::dp_cmd_t   cmd_o
);
  import etfp_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.coord_mul = 1'b1;
          state_d         = ST_FORM;
        end
      end
      ST_FORM: begin
        cmd_o.start = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.stop) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ETFP_ASSERT_NEXT(a_accept_to_form, s_valid_i && s_ready_o, state_q == ST_FORM, "request accepted but point not formed next")
  `ETFP_ASSERT_NEXT(a_mul_to_check, state_q == ST_MUL, state_q == ST_CHECK, "multiply step not followed by escape test")
  `ETFP_ASSERT_NEXT(a_done_delivers, (state_q == ST_DONE) && (!m_valid_q || m_ready_i), m_valid_q && (state_q == ST_IDLE), "finished result not presented")

endmodule

FILE: src/etfp_datapath.sv
`include "escape_time_fractal_pixel_core_macros.svh"

module etfp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  etfp_pkg::cfg_t        cfg_i,
  input  etfp_pkg::dp_cmd_t     cmd_i,
  input  logic [11:0]           row_i,
  input  logic [11:0]           col_i,
  output etfp_pkg::dp_status_t  status_o,
  output logic [7:0]            color_o
);
  import etfp_pkg::*;

  logic [COORD_W-1:0] row_mod, col_mod;
  logic signed [31:0] mul_a0, mul_b0, mul_a1, mul_b1, mul_a2, mul_b2;
  logic signed [63:0] prod_a_q, prod_b_q, prod_c_q;
  logic [31:0]        zr_q, zi_q, cr_q, ci_q;
  logic [LIMIT_W-1:0] count_q;
  logic [COLOR_W-1:0] color_q;
  logic [31:0]        pt_re, pt_im;
  logic [63:0]        mag;

  assign row_mod = COORD_W'({20'd0, row_i} % IMAGE_SIDE);
  assign col_mod = COORD_W'({20'd0, col_i} % IMAGE_SIDE);

  // Share the first two multipliers between coordinate setup and iteration
  always_comb begin
    if (cmd_i.coord_mul) begin
      mul_a0 = signed'({20'd0, col_mod});
      mul_b0 = signed'({1'b0, cfg_i.pixel_pitch});
      mul_a1 = signed'({20'd0, row_mod});
      mul_b1 = signed'({1'b0, cfg_i.pixel_pitch});
    end else begin
      mul_a0 = signed'(zr_q);
      mul_b0 = signed'(zr_q);
      mul_a1 = signed'(zi_q);
      mul_b1 = signed'(zi_q);
    end
    mul_a2 = signed'(zr_q);
    mul_b2 = signed'(zi_q);
  end

  assign pt_re = cfg_i.origin_re + prod_a_q[31:0];
  assign pt_im = cfg_i.origin_im + prod_b_q[31:0];

  // Exact |z|^2; both squares are nonnegative and at most 2^62
  assign mag = prod_a_q + prod_b_q;
  assign status_o.stop = (count_q >= cfg_i.iteration_limit) || (mag >= ESCAPE_SQ);
  assign color_o = color_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_mul || cmd_i.sq_mul) begin
      prod_a_q <= mul_a0 * mul_b0;
      prod_b_q <= mul_a1 * mul_b1;
      prod_c_q <= mul_a2 * mul_b2;
    end
    if (cmd_i.start) begin
      count_q <= '0;
      if (cfg_i.fractal_mode == MODE_JULIA) begin
        zr_q <= pt_re;
        zi_q <= pt_im;
        cr_q <= cfg_i.julia_re;
        ci_q <= cfg_i.julia_im;
      end else begin
        zr_q <= '0;
        zi_q <= '0;
        cr_q <= pt_re;
        ci_q <= pt_im;
      end
    end
    if (cmd_i.advance) begin
      // floor of each product to Q4.28, sums wrap
      zr_q    <= prod_a_q[FRAC_BITS+31:FRAC_BITS] - prod_b_q[FRAC_BITS+31:FRAC_BITS] + cr_q;
      zi_q    <= {prod_c_q[FRAC_BITS+30:FRAC_BITS], 1'b0} + ci_q;
      count_q <= count_q + LIMIT_W'(1);
    end
    if (cmd_i.load_out) begin
      color_q <= COLOR_W'({16'd0, count_q} % COLOR_COUNT);
    end
  end

  `ETFP_ASSERT_NOW(a_count_below_limit, cmd_i.advance, count_q < cfg_i.iteration_limit, "iteration past the limit")
  `ETFP_ASSERT_NEXT(a_count_steps, cmd_i.advance, count_q == $past(count_q) + LIMIT_W'(1), "count did not step by one")
  `ETFP_ASSERT_NEXT(a_color_from_count, cmd_i.load_out, color_q == $past(COLOR_W'({16'd0, count_q} % COLOR_COUNT)), "color index does not match count")

endmodule

FILE: src/escape_time_fractal_pixel_core.sv
// Escape-time fractal pixel core (Mandelbrot / Julia). Send one request per
// pixel with the row and column; the core forms the point origin + index *
// pixel_pitch (Q4.28, wrapping), iterates z = z*z + c while |z|^2 < 4 and the
// count is below iteration_limit, and returns the count modulo the palette
// size as an 8-bit color index. The number of iterations run never exceeds
// iteration_limit. Each iteration is a multiply step on the three 32x32
// multipliers (two of them shared with the coordinate setup), followed by
// the exact |z|^2 escape test and the z update. Only one pixel is in flight;
// a new request is taken as soon as the previous result has moved into the
// output register, even while that result still waits downstream.
// Configuration may only be written while the core is idle.
module escape_time_fractal_pixel_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [etfp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // pixel requests
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [23:0]                        s_axis_tdata_i,  // [11:0] pixel_row, [23:12] pixel_col
  // color results
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o   // [7:0] color_index
);
  import etfp_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fractal_mode    <= MODE_MANDELBROT;
      cfg_q.origin_re       <= '0;
      cfg_q.origin_im       <= '0;
      cfg_q.pixel_pitch     <= '0;
      cfg_q.iteration_limit <= 16'd256;
      cfg_q.julia_re        <= '0;
      cfg_q.julia_im        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRACTAL_MODE:    cfg_q.fractal_mode    <= cfg_wdata_i[0];
        CFG_ORIGIN_RE:       cfg_q.origin_re       <= signed'(cfg_wdata_i);
        CFG_ORIGIN_IM:       cfg_q.origin_im       <= signed'(cfg_wdata_i);
        CFG_PIXEL_PITCH:     cfg_q.pixel_pitch     <= cfg_wdata_i[30:0];
        CFG_ITERATION_LIMIT: cfg_q.iteration_limit <= cfg_wdata_i[15:0];
        CFG_JULIA_RE:        cfg_q.julia_re        <= signed'(cfg_wdata_i);
        CFG_JULIA_IM:        cfg_q.julia_im        <= signed'(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // Sequencer: accept, form point, iterate, deliver
  etfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Multipliers, z/c registers, escape test and output register
  etfp_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .row_i    (s_axis_tdata_i[11:0]),
    .col_i    (s_axis_tdata_i[23:12]),
    .status_o (status),
    .color_o  (m_axis_tdata_o)
  );

endmodule

FILE: tb/tb.sv
module tb;
  import etfp_pkg::*;

  // Register index with no register behind it; a write there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 194;
  // Output hold-off long enough for the core to fill and stall its input
  localparam int unsigned HOLD_CYCLES     = 2000;
  // Quiet cycles before a register write and after the last result
  localparam int unsigned IDLE_SETTLE     = 8;
  localparam int unsigned END_SETTLE      = 600;
  // Slowest legal run: ~1550 pixels at iteration limits up to 256 plus long gaps
  // and stalls, one 65535-iteration pixel and the long output hold-off; the
  // watchdog allows about three times the length of that run.
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;

  typedef enum bit {STEP_WRITE, STEP_PIXEL} step_kind_e;

  // One directed step: a register write, or a pixel request whose data holds
  // {8'd0, col, row}; known marks a result typed in by hand.
  typedef struct {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    bit                   known;
    logic [7:0]           color;
  } dir_step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [23:0]           s_axis_tdata_i;   // [11:0] pixel_row, [23:12] pixel_col
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [7:0]            m_axis_tdata_o;   // [7:0] color_index

  // Mirror of the core's registers, updated as each write lands
  cfg_t        core_cfg;
  logic [7:0]  color_expect_q[$];
  dir_step_t   directed_steps[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  bit          hold_served;

  int unsigned error_count;
  int unsigned results_checked;
  int unsigned pixels_sent;
  int unsigned directed_count;
  int unsigned regs_written;
  int unsigned stall_run;
  int unsigned longest_input_stall;
  int unsigned cycle_count;
  logic [7:0]  want_color;

  escape_time_fractal_pixel_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Q4.28 product: exact 64-bit product, floor shift by the fraction, wrap
  function automatic int fixed_mul(input int a, input int b);
    longint prod;
    prod = longint'(a) * b;
    return int'(prod >>> FRAC_BITS);
  endfunction

  // Predict the color index of one pixel from the mirrored registers
  function automatic logic [7:0] escape_color(input logic [11:0] row, input logic [11:0] col);
    logic [31:0] pt_re;
    logic [31:0] pt_im;
    logic [63:0] mag;
    int          zr, zi, cr, ci, nr, ni;
    int unsigned steps;
    // Form the point modulo 2^32
    pt_re = core_cfg.origin_re + col * core_cfg.pixel_pitch;
    pt_im = core_cfg.origin_im + row * core_cfg.pixel_pitch;
    if (core_cfg.fractal_mode == MODE_JULIA) begin
      zr = pt_re;
      zi = pt_im;
      cr = core_cfg.julia_re;
      ci = core_cfg.julia_im;
    end else begin
      zr = 0;
      zi = 0;
      cr = pt_re;
      ci = pt_im;
    end
    steps = 0;
    while (steps < core_cfg.iteration_limit) begin
      // Exact |z|^2 in Q8.56; the sum of two squares fits 64 unsigned bits
      mag = longint'(zr) * zr + longint'(zi) * zi;
      if (mag >= ESCAPE_SQ) break;
      nr = fixed_mul(zr, zr) - fixed_mul(zi, zi) + cr;
      ni = fixed_mul(zr, zi) + fixed_mul(zi, zr) + ci;
      zr = nr;
      zi = ni;
      steps++;
    end
    return 8'(steps % COLOR_COUNT);
  endfunction

  // Write one register, then update the mirror the way the core decodes it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_FRACTAL_MODE:    core_cfg.fractal_mode    = value[0];
      CFG_ORIGIN_RE:       core_cfg.origin_re       = value;
      CFG_ORIGIN_IM:       core_cfg.origin_im       = value;
      CFG_PIXEL_PITCH:     core_cfg.pixel_pitch     = value[30:0];
      CFG_ITERATION_LIMIT: core_cfg.iteration_limit = value[15:0];
      CFG_JULIA_RE:        core_cfg.julia_re        = value;
      CFG_JULIA_IM:        core_cfg.julia_im        = value;
      default: ;
    endcase
    regs_written++;
  endtask

  // Offer one pixel request after a random gap, hold it until accepted, and
  // queue its expected color
  task automatic send_pixel(input logic [11:0] row, input logic [11:0] col,
                            input bit known, input logic [7:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {col, row};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    color_expect_q.push_back(known ? color : escape_color(row, col));
    pixels_sent++;
  endtask

  // Drop the request line and wait until every queued color has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (color_expect_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  // Receiver: random stalls per phase, plus one long hold-off on request
  initial begin
    hold_served = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_served) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_served = 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Scoreboard: compare each delivered color with the oldest prediction, and
  // track how long the core holds off its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        stall_run++;
        if (stall_run > longest_input_stall) longest_input_stall = stall_run;
      end else begin
        stall_run = 0;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (color_expect_q.size() == 0) begin
          $display("%0t: color_index with nothing pending: expected none, actual %0d",
                   $time, m_axis_tdata_o);
          error_count++;
        end else begin
          want_color = color_expect_q.pop_front();
          if (m_axis_tdata_o !== want_color) begin
            $display("%0t: color_index mismatch: expected %0d, actual %0d",
                     $time, want_color, m_axis_tdata_o);
            error_count++;
          end
          results_checked++;
        end
      end
    end
  end

  // Watchdog: end a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    dir_step_t   cur;
    logic        mode;
    logic [31:0] ore, oim, pitch, jre, jim;
    logic [15:0] limit;

    error_count         = 0;
    results_checked     = 0;
    pixels_sent         = 0;
    directed_count      = 0;
    regs_written        = 0;
    stall_run           = 0;
    longest_input_stall = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 1'b0;
    core_cfg = '{fractal_mode: MODE_MANDELBROT, origin_re: '0, origin_im: '0,
                 pixel_pitch: '0, iteration_limit: 16'd256, julia_re: '0, julia_im: '0};

    // Directed steps. With pitch 0 every pixel maps to the origin, so the
    // early results follow from the register values alone.
    directed_steps = '{
      // after reset: c = 0 never escapes, 256 steps wrap to color 0
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'hFFF, 12'hFFF}, 1'b1, 8'd0},
      // zero limit runs no step
      '{STEP_WRITE, CFG_ITERATION_LIMIT, 32'd0, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'h555, 12'hAAA}, 1'b1, 8'd0},
      '{STEP_WRITE, CFG_ITERATION_LIMIT, 32'd1, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'hAAA, 12'h555}, 1'b1, 8'd1},
      '{STEP_WRITE, CFG_ITERATION_LIMIT, 32'd255, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd7, 12'd9}, 1'b1, 8'd255},
      // count past the palette wraps
      '{STEP_WRITE, CFG_ITERATION_LIMIT, 32'd257, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd3, 12'd5}, 1'b1, 8'd1},
      // c = -6 escapes after one step
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'hA000_0000, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd1},
      // |z|^2 exactly 4 stops; just below 4 goes on
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'h2000_0000, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd1},
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'h1FFF_FFFF, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd2},
      // Julia: z starts at the point
      '{STEP_WRITE, CFG_FRACTAL_MODE, {31'd0, MODE_JULIA}, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd1},
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'h2000_0000, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'h8000_0000, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_IM, 32'h8000_0000, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd0},
      // Julia view around c = -0.8 + 0.156i
      '{STEP_WRITE, CFG_JULIA_RE, 32'hF333_3333, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_JULIA_IM, 32'h0280_0000, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'hE800_0000, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_IM, 32'hF000_0000, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_PIXEL_PITCH, 32'h0003_0000, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ITERATION_LIMIT, 32'd64, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd2048, 12'd2048}, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd2730, 12'd1365}, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'h000, 12'hFFF}, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'hFFF, 12'h000}, 1'b0, 8'd0},
      // back to Mandelbrot; only bit 0 of the mode write counts
      '{STEP_WRITE, CFG_FRACTAL_MODE, 32'hFFFF_FFFE, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'hE000_0000, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_IM, 32'hE800_0000, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd2730, 12'd2048}, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'h555, 12'h800}, 1'b0, 8'd0},
      // widest pitch (bit 31 of the write dropped): coordinates wrap
      '{STEP_WRITE, CFG_PIXEL_PITCH, 32'hFFFF_FFFF, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_RE, 32'h0000_0000, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ORIGIN_IM, 32'h0000_0000, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'hFFF, 12'hFFF}, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd1, 12'd1}, 1'b0, 8'd0},
      // write to an index with no register: no effect
      '{STEP_WRITE, CFG_UNUSED, 32'hFFFF_FFFF, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'hFFF, 12'hFFF}, 1'b0, 8'd0},
      // largest limit with c = 0: 65535 steps, color 255
      '{STEP_WRITE, CFG_PIXEL_PITCH, 32'd0, 1'b0, 8'd0},
      '{STEP_WRITE, CFG_ITERATION_LIMIT, 32'hFFFF_FFFF, 1'b0, 8'd0},
      '{STEP_PIXEL, '0, {8'd0, 12'd0, 12'd0}, 1'b1, 8'd255}
    };

    // Hold every input at a known value, then release reset once
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; drain before each register write
    foreach (directed_steps[k]) begin
      cur = directed_steps[k];
      if (cur.kind == STEP_WRITE) begin
        drain_results();
        write_reg(cur.idx, cur.data);
      end else begin
        send_pixel(cur.data[11:0], cur.data[23:12], cur.known, cur.color);
        directed_count++;
      end
    end

    // Random phases: each picks a register setting and an idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase

      // Unused registers still get random values
      mode  = $urandom_range(1);
      jre   = $urandom;
      jim   = $urandom;
      ore   = 32'hE000_0000;
      oim   = 32'hE800_0000;
      pitch = 32'h0003_0000;
      limit = 16'($urandom_range(16, 40));
      case (ph)
        0: mode = MODE_MANDELBROT;
        1, 7: begin
          // Julia over a 4 x 4 square, c with both parts within [-1, 1]
          mode  = MODE_JULIA;
          oim   = 32'hE000_0000;
          pitch = 32'h0004_0000;
          jre   = $urandom_range(32'h2000_0000) - 32'h1000_0000;
          jim   = $urandom_range(32'h2000_0000) - 32'h1000_0000;
          limit = (ph == 7) ? 16'd8 : 16'($urandom_range(24, 48));
        end
        2: begin
          // deep zoom near the set boundary
          mode  = MODE_MANDELBROT;
          ore   = 32'hF400_0000;
          oim   = 32'h0199_999A;
          pitch = $urandom_range(1, 255);
          limit = 16'd64;
        end
        3: begin
          // every bit of the mode, origin, pitch and Julia c random
          ore   = $urandom;
          oim   = $urandom;
          pitch = $urandom;
          limit = 16'($urandom_range(1, 40));
        end
        4: begin
          mode  = MODE_MANDELBROT;
          limit = 16'd256;
        end
        5: begin
          // most negative origin, widest pitch, largest c and limit; every
          // point escapes within one step
          mode  = MODE_JULIA;
          ore   = 32'h8000_0000;
          oim   = 32'h8000_0000;
          pitch = 32'h7FFF_FFFF;
          limit = 16'hFFFF;
          jre   = 32'h7FFF_FFFF;
          jim   = 32'h8000_0000;
        end
        default: begin
          // most positive origin, random wrapping pitch, tiny limits
          mode  = MODE_MANDELBROT;
          ore   = 32'h7FFF_FFFF;
          oim   = 32'h7FFF_FFFF;
          pitch = $urandom;
          limit = 16'($urandom_range(0, 12));
        end
      endcase
      write_reg(CFG_FRACTAL_MODE, {31'd0, mode});
      write_reg(CFG_ORIGIN_RE, ore);
      write_reg(CFG_ORIGIN_IM, oim);
      write_reg(CFG_PIXEL_PITCH, pitch);
      write_reg(CFG_ITERATION_LIMIT, {16'd0, limit});
      write_reg(CFG_JULIA_RE, jre);
      write_reg(CFG_JULIA_IM, jim);

      // Last phase: stall the output for a long stretch while requests keep
      // coming, so the core backs up into its input
      if (ph == PHASES - 1) hold_req = 1'b1;

      repeat (ITEMS_PER_PHASE) begin
        send_pixel(12'($urandom_range(IMAGE_SIDE - 1)), 12'($urandom_range(IMAGE_SIDE - 1)),
                   1'b0, 8'd0);
      end
    end

    // Drain, then give a stray result time to show up
    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);

    $display("tb: %0d pixels checked (%0d directed) over %0d register writes",
             results_checked, directed_count, regs_written);
    $display("tb: both fractal modes, limits 0 to 65535, input held off up to %0d cycles",
             longest_input_stall);
    if (error_count == 0 && color_expect_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/etfp_pkg.sv
src/etfp_ctrl.sv
src/etfp_datapath.sv
src/escape_time_fractal_pixel_core.sv
tb/tb.sv
